// File: sv/fmprf_pkg.sv
// fmprf_pkg: types, codes and helper functions of the first-match packet rule filter
// shared by the front end, back end and top level; no dependencies
`default_nettype none

package fmprf_pkg;

  // ip protocol numbers and port class boundary
  localparam logic [7:0]  PROTO_TCP       = 8'd6;
  localparam logic [7:0]  PROTO_UDP       = 8'd17;
  localparam logic [15:0] PORT_HIGH_LIMIT = 16'd1023;

  // configuration register indexes
  localparam logic [1:0] CFG_FILTER_ACTIVE = 2'd0;
  localparam logic [1:0] CFG_RULE_COUNT    = 2'd1;
  localparam logic [1:0] CFG_ANY_PROTOCOL  = 2'd2;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned COUNT_W     = 5;

  // reset values of the configuration registers
  localparam logic [7:0] ANY_PROTOCOL_RESET = 8'd143;

  // reason codes on the result side
  localparam logic [1:0] REASON_INACTIVE = 2'd0;
  localparam logic [1:0] REASON_XMAS     = 2'd1;
  localparam logic [1:0] REASON_NO_MATCH = 2'd2;
  localparam logic [1:0] REASON_MATCHED  = 2'd3;

  // verdict codes
  localparam logic VERDICT_DROP   = 1'b0;
  localparam logic VERDICT_ACCEPT = 1'b1;

  // kind of work handed from front to back
  localparam logic [1:0] KIND_SEARCH = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  // configuration register file
  typedef struct packed {
    logic               active;
    logic [COUNT_W-1:0] rule_count;
    logic [7:0]         any_proto;
  } cfg_t;

  // one rule table entry
  typedef struct packed {
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [1:0]  dir;
    logic [7:0]  proto;
    logic [1:0]  ack;
    logic        verd;
  } rule_t;

  // word in the queue between front and back
  // write: rule fields; search: normalized packet; done: verd and reason hold the result
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  idx;
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [1:0]  dir;
    logic [7:0]  proto;
    logic [1:0]  ack;
    logic        verd;
    logic [1:0]  reason;
  } item_t;

  // result word
  typedef struct packed {
    logic       verdict;
    logic [1:0] reason;
    logic [3:0] matched_rule;
  } res_t;

  // rule port 0 is a wildcard, two ports above the limit are one class
  function automatic logic port_ok(input logic [15:0] pkt, input logic [15:0] rl);
    logic hi_both;
    hi_both = (rl > PORT_HIGH_LIMIT) && (pkt > PORT_HIGH_LIMIT);
    return (rl == 16'd0) || hi_both || (rl == pkt);
  endfunction

  // rule address 0 is a wildcard
  function automatic logic addr_ok(input logic [31:0] pkt, input logic [31:0] rl);
    return (rl == 32'd0) || (rl == pkt);
  endfunction

endpackage

`default_nettype wire

// File: sv/fmprf_ram.sv
// fmprf_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module fmprf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/fmprf_fifo.sv
// fmprf_fifo: small register queue with full and empty flags
// no dependencies
`default_nettype none

module fmprf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// File: sv/fmprf_front.sv
// fmprf_front: accepts input words, sorts them into rule writes, early verdicts
// and searches, and queues them for the back end; uses fmprf_pkg and fmprf_fifo
`default_nettype none

module fmprf_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire fmprf_pkg::cfg_t cfg,
  input  wire logic           push,
  output logic                full,
  input  wire logic           action,
  input  wire logic [3:0]     rule_index,
  input  wire logic [1:0]     direction,
  input  wire logic [7:0]     protocol,
  input  wire logic [31:0]    source_address,
  input  wire logic [31:0]    dest_address,
  input  wire logic [15:0]    source_port,
  input  wire logic [15:0]    dest_port,
  input  wire logic [1:0]     ack_mask,
  input  wire logic [3:0]     tcp_flags,
  input  wire logic           rule_verdict,
  input  wire logic           item_pop,
  output fmprf_pkg::item_t    item,
  output logic                item_empty
);

  import fmprf_pkg::*;

  item_t item_in;
  logic  is_tcp;
  logic  has_ports;
  logic  xmas;
  logic  [$bits(item_t)-1:0] item_bits;

  assign is_tcp    = (protocol == PROTO_TCP);
  assign has_ports = is_tcp || (protocol == PROTO_UDP);
  assign xmas      = is_tcp && (tcp_flags[2:0] == 3'b111);

  // classify the incoming word
  always_comb begin
    item_in.idx    = rule_index;
    item_in.saddr  = source_address;
    item_in.daddr  = dest_address;
    item_in.dir    = direction;
    item_in.proto  = protocol;
    item_in.sport  = source_port;
    item_in.dport  = dest_port;
    item_in.ack    = ack_mask;
    item_in.verd   = rule_verdict;
    item_in.reason = REASON_NO_MATCH;
    if (action) begin
      item_in.kind = KIND_WRITE;
    end else if (!cfg.active) begin
      item_in.kind   = KIND_DONE;
      item_in.verd   = VERDICT_ACCEPT;
      item_in.reason = REASON_INACTIVE;
    end else if (xmas) begin
      item_in.kind   = KIND_DONE;
      item_in.verd   = VERDICT_DROP;
      item_in.reason = REASON_XMAS;
    end else begin
      // normalize ports and ack code of the packet
      item_in.kind = KIND_SEARCH;
      if (!has_ports) begin
        item_in.sport = '0;
        item_in.dport = '0;
      end
      if (is_tcp) begin
        item_in.ack = tcp_flags[3] ? 2'b10 : 2'b01;
      end else begin
        item_in.ack = 2'b11;
      end
    end
  end

  // decoupling queue toward the back end
  fmprf_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (2)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (item_in),
    .full  (full),
    .pop   (item_pop),
    .rdata (item_bits),
    .empty (item_empty)
  );

  assign item = item_t'(item_bits);

endmodule

`default_nettype wire

// File: sv/fmprf_back.sv
// fmprf_back: carries out queued work: rule table writes and the first-match
// scan, one rule per cycle, into the result queue; uses fmprf_pkg, fmprf_ram, fmprf_fifo
`default_nettype none

module fmprf_back #(
  parameter int unsigned RULE_ENTRIES = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire fmprf_pkg::cfg_t cfg,
  input  wire fmprf_pkg::item_t item,
  input  wire logic            item_empty,
  output logic                 item_pop,
  input  wire logic            pop,
  output logic                 empty,
  output fmprf_pkg::res_t      res
);

  import fmprf_pkg::*;

  localparam int unsigned IDX_W  = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;
  localparam int unsigned LIM_W  = ($clog2(RULE_ENTRIES + 1) > COUNT_W) ?
                                   $clog2(RULE_ENTRIES + 1) : COUNT_W;
  localparam logic [LIM_W-1:0] LIM_MAX = LIM_W'(RULE_ENTRIES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [IDX_W-1:0] scan;
  logic [IDX_W-1:0] scan_next;
  item_t            pkt;
  item_t            pkt_next;
  res_t             res_hold;
  res_t             res_hold_next;
  res_t             out_word;
  res_t             scan_res;
  logic             out_push;
  logic             out_full;
  logic             ram_we;
  logic             in_range;
  logic [LIM_W-1:0] limit;
  logic [LIM_W-1:0] count_ext;
  logic             last;
  logic             match;
  rule_t            rule;
  rule_t            rule_in;
  logic [$bits(rule_t)-1:0] rule_bits;
  logic [$bits(res_t)-1:0]  res_bits;

  // number of entries searched
  assign count_ext = LIM_W'(cfg.rule_count);
  assign limit     = (count_ext > LIM_MAX) ? LIM_MAX : count_ext;
  assign last      = ((LIM_W'(scan) + LIM_W'(1)) >= limit);

  // rule entry from a write word
  assign in_range = (32'(item.idx) < RULE_ENTRIES);
  always_comb begin
    rule_in.saddr = item.saddr;
    rule_in.daddr = item.daddr;
    rule_in.sport = item.sport;
    rule_in.dport = item.dport;
    rule_in.dir   = item.dir;
    rule_in.proto = item.proto;
    rule_in.ack   = item.ack;
    rule_in.verd  = item.verd;
  end

  // rule table, read address is the next value of the scan pointer
  fmprf_ram #(
    .WIDTH ($bits(rule_t)),
    .DEPTH (RULE_ENTRIES)
  ) u_rules (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(item.idx)),
    .wdata (rule_in),
    .raddr (scan_next),
    .rdata (rule_bits)
  );

  assign rule = rule_t'(rule_bits);

  // match of the packet against the entry under the scan pointer
  assign match = ((pkt.dir & rule.dir) != 2'b00)
              && ((rule.proto == cfg.any_proto) || (rule.proto == pkt.proto))
              && ((pkt.ack & rule.ack) != 2'b00)
              && port_ok(pkt.sport, rule.sport)
              && port_ok(pkt.dport, rule.dport)
              && addr_ok(pkt.saddr, rule.saddr)
              && addr_ok(pkt.daddr, rule.daddr);

  always_comb begin
    if (match) begin
      scan_res.verdict      = rule.verd;
      scan_res.reason       = REASON_MATCHED;
      scan_res.matched_rule = 4'(scan);
    end else begin
      scan_res.verdict      = VERDICT_ACCEPT;
      scan_res.reason       = REASON_NO_MATCH;
      scan_res.matched_rule = '0;
    end
  end

  // sequencer
  always_comb begin
    item_pop      = 1'b0;
    ram_we        = 1'b0;
    out_push      = 1'b0;
    out_word      = res_hold;
    state_next    = state;
    scan_next     = '0;
    pkt_next      = pkt;
    res_hold_next = res_hold;
    unique case (state)
      ST_IDLE: begin
        if (!item_empty) begin
          unique case (item.kind)
            KIND_WRITE: begin
              item_pop = 1'b1;
              ram_we   = in_range;
            end
            KIND_DONE: begin
              if (!out_full) begin
                item_pop              = 1'b1;
                out_push              = 1'b1;
                out_word.verdict      = item.verd;
                out_word.reason       = item.reason;
                out_word.matched_rule = '0;
              end
            end
            KIND_SEARCH: begin
              item_pop = 1'b1;
              pkt_next = item;
              if (limit == '0) begin
                res_hold_next.verdict      = VERDICT_ACCEPT;
                res_hold_next.reason       = REASON_NO_MATCH;
                res_hold_next.matched_rule = '0;
                state_next                 = ST_HOLD;
              end else begin
                state_next = ST_SCAN;
              end
            end
            default: begin
              item_pop = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (match || last) begin
          if (!out_full) begin
            out_push   = 1'b1;
            out_word   = scan_res;
            state_next = ST_IDLE;
          end else begin
            res_hold_next = scan_res;
            state_next    = ST_HOLD;
          end
        end else begin
          scan_next = scan + IDX_W'(1);
        end
      end
      ST_HOLD: begin
        if (!out_full) begin
          out_push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      scan  <= '0;
    end else begin
      state <= state_next;
      scan  <= scan_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pkt      <= pkt_next;
    res_hold <= res_hold_next;
  end

  // result queue
  fmprf_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (2)
  ) u_results (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_word),
    .full  (out_full),
    .pop   (pop),
    .rdata (res_bits),
    .empty (empty)
  );

  assign res = res_t'(res_bits);

endmodule

`default_nettype wire

// File: sv/first_match_packet_rule_filter.sv
// first_match_packet_rule_filter: top level of the five-tuple first-match classifier
// uses fmprf_pkg, fmprf_front and fmprf_back
`default_nettype none

// Stateless packet classifier with a table of RULE_ENTRIES rules. Words pushed
// in either write a rule entry (action 1) or classify a packet header (action 0);
// each classify word yields exactly one result word, write words yield none.
// The front end sorts words as they arrive and settles inactive-filter and
// christmas-tree packets at once; a two-word queue feeds the back end, so the
// input keeps accepting while a search runs. The back end scans the rule table
// one entry per cycle through the table ram's registered read port: a classify
// word that needs a search examines entries up to the first match, at most
// min(rule_count, RULE_ENTRIES) of them, and holds the back end until its result
// is queued; a search with a rule_count of zero examines none. A full result
// queue holds a finished result back until there is room. Results wait in a
// two-word output queue.
// Configuration registers (0 filter_active, 1 rule_count, 2 any_protocol_code)
// are to be written by the user only while the block is idle; the block does
// not enforce this; rule entries must be written before rule_count covers them.
module first_match_packet_rule_filter #(
  parameter int unsigned RULE_ENTRIES = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [fmprf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [fmprf_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input side
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic                                action,
  input  wire logic [3:0]                          rule_index,
  input  wire logic [1:0]                          direction,
  input  wire logic [7:0]                          protocol,
  input  wire logic [31:0]                         source_address,
  input  wire logic [31:0]                         dest_address,
  input  wire logic [15:0]                         source_port,
  input  wire logic [15:0]                         dest_port,
  input  wire logic [1:0]                          ack_mask,
  input  wire logic [3:0]                          tcp_flags,
  input  wire logic                                rule_verdict,
  // result side
  output logic                                     empty,
  input  wire logic                                pop,
  output logic                                     verdict,
  output logic [1:0]                               reason,
  output logic [3:0]                               matched_rule
);

  import fmprf_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_empty;
  logic  item_pop;
  res_t  res;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active     <= 1'b0;
      cfg.rule_count <= '0;
      cfg.any_proto  <= ANY_PROTOCOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FILTER_ACTIVE: cfg.active     <= cfg_data[0];
        CFG_RULE_COUNT:    cfg.rule_count <= cfg_data[COUNT_W-1:0];
        CFG_ANY_PROTOCOL:  cfg.any_proto  <= cfg_data;
        default: ;
      endcase
    end
  end

  // front end: accept and sort
  fmprf_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .push           (push),
    .full           (full),
    .action         (action),
    .rule_index     (rule_index),
    .direction      (direction),
    .protocol       (protocol),
    .source_address (source_address),
    .dest_address   (dest_address),
    .source_port    (source_port),
    .dest_port      (dest_port),
    .ack_mask       (ack_mask),
    .tcp_flags      (tcp_flags),
    .rule_verdict   (rule_verdict),
    .item_pop       (item_pop),
    .item           (item),
    .item_empty     (item_empty)
  );

  // back end: table writes and rule scan
  fmprf_back #(
    .RULE_ENTRIES (RULE_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (item),
    .item_empty (item_empty),
    .item_pop   (item_pop),
    .pop        (pop),
    .empty      (empty),
    .res        (res)
  );

  assign verdict      = res.verdict;
  assign reason       = res.reason;
  assign matched_rule = res.matched_rule;

endmodule

`default_nettype wire

// File: sv/fmprf_checker.sv
// fmprf_checker: port-level assertions for first_match_packet_rule_filter
// bound to the top level; uses fmprf_pkg
`default_nettype none

module fmprf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic       verdict,
  input wire logic [1:0] reason,
  input wire logic [3:0] matched_rule
);

  import fmprf_pkg::*;

  // both queues come out of reset empty
  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // a waiting result holds until taken
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable({verdict, reason, matched_rule})))
    else $error("waiting result changed or vanished");

  // an inactive filter or a search without a match always accepts
  a_bypass_accepts: assert property (@(posedge clk) disable iff (rst)
    (!empty && (reason == REASON_INACTIVE || reason == REASON_NO_MATCH)) |-> verdict)
    else $error("bypass or no-match result not accepted");

  // christmas-tree packets are always dropped
  a_xmas_drops: assert property (@(posedge clk) disable iff (rst)
    (!empty && reason == REASON_XMAS) |-> !verdict)
    else $error("christmas packet not dropped");

  // rule index only reported on a match
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && reason != REASON_MATCHED) |-> (matched_rule == 4'd0))
    else $error("matched_rule set without a match");

endmodule

bind first_match_packet_rule_filter fmprf_checker u_fmprf_checker (.*);

`default_nettype wire

// File: tb/first_match_packet_rule_filter_tb.sv
// first_match_packet_rule_filter_tb: self-checking testbench of the first-match rule filter
// drives rule writes and packet headers, predicts each verdict and checks it in order
// depends on fmprf_pkg and first_match_packet_rule_filter
`default_nettype none

module first_match_packet_rule_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fmprf_pkg::*;

  localparam int TABLE_DEPTH   = 16;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASES        = 8;
  localparam int PHASE_WORDS   = 150;
  localparam int RANDOM_SETTING = -1;

  // word kinds, register index without a register, extra protocol numbers
  localparam logic       ACT_CLASSIFY = 1'b0;
  localparam logic       ACT_WRITE    = 1'b1;
  localparam logic [1:0] CFG_UNUSED   = 2'd3;
  localparam logic [7:0] PROTO_ICMP   = 8'd1;
  localparam logic [7:0] PROTO_GRE    = 8'd47;

  // packet direction and rule direction mask
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_IN   = 2'd1;
  localparam logic [1:0] DIR_OUT  = 2'd2;
  localparam logic [1:0] DIR_BOTH = 2'd3;

  // tcp flag bits and rule ack masks
  localparam logic [3:0] FLAG_FIN   = 4'b0001;
  localparam logic [3:0] FLAG_PSH   = 4'b0010;
  localparam logic [3:0] FLAG_URG   = 4'b0100;
  localparam logic [3:0] FLAG_ACK   = 4'b1000;
  localparam logic [3:0] XMAS_FLAGS = FLAG_FIN | FLAG_PSH | FLAG_URG;
  localparam logic [1:0] ACK_CLEAR_OK = 2'b01;
  localparam logic [1:0] ACK_SET_OK   = 2'b10;
  localparam logic [1:0] ACK_ANY      = 2'b11;

  localparam logic [15:0] HIGH_PORT_FLOOR = 16'd1024;

  // one input word as it goes over the push side
  typedef struct packed {
    logic        action;
    logic [3:0]  idx;
    logic [1:0]  dir;
    logic [7:0]  proto;
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [1:0]  ack;
    logic [3:0]  flags;
    logic        verd;
  } word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data  = '0;

  logic        push = 1'b0;
  logic        full;
  logic        action = 1'b0;
  logic [3:0]  rule_index = '0;
  logic [1:0]  direction = '0;
  logic [7:0]  protocol = '0;
  logic [31:0] source_address = '0;
  logic [31:0] dest_address = '0;
  logic [15:0] source_port = '0;
  logic [15:0] dest_port = '0;
  logic [1:0]  ack_mask = '0;
  logic [3:0]  tcp_flags = '0;
  logic        rule_verdict = 1'b0;

  logic       empty;
  logic       pop = 1'b0;
  logic       verdict;
  logic [1:0] reason;
  logic [3:0] matched_rule;

  // shadow of the filter: rule table and registers
  rule_t      rule_table [TABLE_DEPTH];
  logic       cfg_active = 1'b0;
  logic [4:0] cfg_rule_count = 5'd0;
  logic [7:0] cfg_any_proto = ANY_PROTOCOL_RESET;

  word_t words_to_send [$];
  res_t  verdicts_due [$];
  word_t on_wire;
  res_t  want;
  logic  word_held = 1'b0;
  int    error_count = 0;

  int send_gap_pct = 34;
  int take_gap_pct = 34;
  logic stall_now = 1'b0;
  logic hold_off = 1'b0;

  int active_plan [PHASES] = '{1, 1, 1, 0, 1, 1, 1, 1};
  int count_plan  [PHASES] = '{16, 0, 1, 31, 17, 9, 16, 4};
  int any_plan    [PHASES] = '{143, 0, 255, 6, 17, 143, RANDOM_SETTING, 200};

  first_match_packet_rule_filter #(
    .RULE_ENTRIES(TABLE_DEPTH)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .full          (full),
    .action        (action),
    .rule_index    (rule_index),
    .direction     (direction),
    .protocol      (protocol),
    .source_address(source_address),
    .dest_address  (dest_address),
    .source_port   (source_port),
    .dest_port     (dest_port),
    .ack_mask      (ack_mask),
    .tcp_flags     (tcp_flags),
    .rule_verdict  (rule_verdict),
    .empty         (empty),
    .pop           (pop),
    .verdict       (verdict),
    .reason        (reason),
    .matched_rule  (matched_rule)
  );

  always #4 clk = ~clk;

  task automatic note_error(input string msg);
    error_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  // rule port 0 takes any port, a high rule port takes any high packet port
  function automatic logic port_fits(input logic [15:0] pkt, input logic [15:0] want_port);
    if (want_port == 16'd0) return 1'b1;
    if (want_port >= HIGH_PORT_FLOOR) return pkt >= HIGH_PORT_FLOOR;
    return pkt == want_port;
  endfunction

  // expected verdict of one packet header against the shadow table
  function automatic res_t predict_verdict(input word_t w);
    res_t        res;
    rule_t       e;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [1:0]  ack_code;
    int          span;
    logic        hit;
    res.verdict = VERDICT_ACCEPT;
    res.reason = REASON_INACTIVE;
    res.matched_rule = 4'd0;
    if (!cfg_active) return res;
    sp = w.sport;
    dp = w.dport;
    if (w.proto == PROTO_TCP) begin
      if ((w.flags & XMAS_FLAGS) == XMAS_FLAGS) begin
        res.verdict = VERDICT_DROP;
        res.reason = REASON_XMAS;
        return res;
      end
      ack_code = ((w.flags & FLAG_ACK) != 4'd0) ? ACK_SET_OK : ACK_CLEAR_OK;
    end else begin
      ack_code = ACK_ANY;
      // only tcp and udp carry ports
      if (w.proto != PROTO_UDP) begin
        sp = 16'd0;
        dp = 16'd0;
      end
    end
    span = (int'(cfg_rule_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(cfg_rule_count);
    res.reason = REASON_NO_MATCH;
    hit = 1'b0;
    for (int i = 0; i < span && !hit; i++) begin
      e = rule_table[i];
      if ((w.dir & e.dir) != 2'd0 &&
          (e.proto == cfg_any_proto || e.proto == w.proto) &&
          (ack_code & e.ack) != 2'd0 &&
          port_fits(sp, e.sport) && port_fits(dp, e.dport) &&
          (e.saddr == 32'd0 || e.saddr == w.saddr) &&
          (e.daddr == 32'd0 || e.daddr == w.daddr)) begin
        hit = 1'b1;
        res.verdict = e.verd;
        res.reason = REASON_MATCHED;
        res.matched_rule = 4'(i);
      end
    end
    return res;
  endfunction

  function automatic void store_entry(input word_t w);
    rule_t e;
    e.saddr = w.saddr;
    e.daddr = w.daddr;
    e.sport = w.sport;
    e.dport = w.dport;
    e.dir = w.dir;
    e.proto = w.proto;
    e.ack = w.ack;
    e.verd = w.verd;
    rule_table[w.idx] = e;
  endfunction

  function automatic word_t make_rule(input logic [3:0] idx, input logic [1:0] dir,
                                      input logic [7:0] proto, input logic [31:0] saddr,
                                      input logic [31:0] daddr, input logic [15:0] sport,
                                      input logic [15:0] dport, input logic [1:0] ack,
                                      input logic verd);
    word_t w;
    w.action = ACT_WRITE;
    w.idx = idx;
    w.dir = dir;
    w.proto = proto;
    w.saddr = saddr;
    w.daddr = daddr;
    w.sport = sport;
    w.dport = dport;
    w.ack = ack;
    w.flags = 4'($urandom_range(0, 15));
    w.verd = verd;
    return w;
  endfunction

  function automatic word_t make_packet(input logic [1:0] dir, input logic [7:0] proto,
                                        input logic [31:0] saddr, input logic [31:0] daddr,
                                        input logic [15:0] sport, input logic [15:0] dport,
                                        input logic [3:0] flags);
    word_t w;
    w.action = ACT_CLASSIFY;
    w.idx = 4'($urandom_range(0, 15));
    w.dir = dir;
    w.proto = proto;
    w.saddr = saddr;
    w.daddr = daddr;
    w.sport = sport;
    w.dport = dport;
    w.ack = 2'($urandom_range(0, 3));
    w.flags = flags;
    w.verd = 1'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic logic [15:0] rand_rule_port();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'($urandom_range(1, 1023));
      2: return 16'($urandom_range(1024, 65535));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic word_t rand_rule();
    logic [7:0] proto;
    case ($urandom_range(0, 4))
      0: proto = cfg_any_proto;
      1: proto = PROTO_TCP;
      2: proto = PROTO_UDP;
      3: proto = PROTO_ICMP;
      default: proto = 8'($urandom_range(0, 255));
    endcase
    return make_rule(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)), proto,
                     ($urandom_range(0, 1) != 0) ? 32'd0 : 32'($urandom),
                     ($urandom_range(0, 1) != 0) ? 32'd0 : 32'($urandom),
                     rand_rule_port(), rand_rule_port(),
                     2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
  endfunction

  function automatic word_t rand_packet();
    return make_packet(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                       32'($urandom), 32'($urandom),
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       4'($urandom_range(0, 15)));
  endfunction

  // a packet port that a given rule port accepts
  function automatic logic [15:0] pick_port(input logic [15:0] want_port);
    if (want_port == 16'd0) return 16'($urandom_range(0, 65535));
    if (want_port >= HIGH_PORT_FLOOR && $urandom_range(0, 1) != 0)
      return 16'($urandom_range(1024, 65535));
    return want_port;
  endfunction

  // header built to hit a table entry, now and then one bit off
  function automatic word_t packet_from_table();
    rule_t      e;
    logic [1:0] dir;
    logic [7:0] proto;
    word_t      w;
    e = rule_table[$urandom_range(0, TABLE_DEPTH - 1)];
    case (e.dir)
      DIR_BOTH: dir = 2'($urandom_range(1, 3));
      DIR_NONE: dir = 2'($urandom_range(0, 3));
      default:  dir = ($urandom_range(0, 3) == 0) ? DIR_BOTH : e.dir;
    endcase
    if (e.proto == cfg_any_proto) begin
      case ($urandom_range(0, 2))
        0: proto = PROTO_TCP;
        1: proto = PROTO_UDP;
        default: proto = 8'($urandom_range(0, 255));
      endcase
    end else begin
      proto = e.proto;
    end
    w = make_packet(dir, proto,
                    (e.saddr == 32'd0) ? 32'($urandom) : e.saddr,
                    (e.daddr == 32'd0) ? 32'($urandom) : e.daddr,
                    pick_port(e.sport), pick_port(e.dport), 4'($urandom_range(0, 15)));
    if ($urandom_range(0, 9) == 0) w.saddr = w.saddr ^ (32'd1 << $urandom_range(0, 31));
    if ($urandom_range(0, 9) == 0) w.dport = w.dport ^ (16'd1 << $urandom_range(0, 15));
    return w;
  endfunction

  task automatic queue_word(input word_t w);
    while (words_to_send.size() >= 4) @(posedge clk);
    words_to_send.push_back(w);
  endtask

  // everything sent and answered, then let a trailing rule write finish
  task automatic wait_idle();
    while (words_to_send.size() != 0 || word_held || verdicts_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_FILTER_ACTIVE: cfg_active = data[0];
      CFG_RULE_COUNT:    cfg_rule_count = data[4:0];
      CFG_ANY_PROTOCOL:  cfg_any_proto = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // driver: offer the next word at the falling edge, hold it until taken
  always @(negedge clk) begin
    if (!rst && !word_held) begin
      if (words_to_send.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        on_wire = words_to_send.pop_front();
        word_held = 1'b1;
        push <= 1'b1;
        action <= on_wire.action;
        rule_index <= on_wire.idx;
        direction <= on_wire.dir;
        protocol <= on_wire.proto;
        source_address <= on_wire.saddr;
        dest_address <= on_wire.daddr;
        source_port <= on_wire.sport;
        dest_port <= on_wire.dport;
        ack_mask <= on_wire.ack;
        tcp_flags <= on_wire.flags;
        rule_verdict <= on_wire.verd;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // accepted word: update the table or queue the expected verdict
  always @(posedge clk) begin
    if (!rst && push && !full) begin
      if (on_wire.action == ACT_WRITE) store_entry(on_wire);
      else verdicts_due.push_back(predict_verdict(on_wire));
      word_held = 1'b0;
    end
  end

  // receiver readiness, with the long hold-off when asked
  always @(negedge clk) begin
    pop <= !hold_off && ($urandom_range(0, 99) >= take_gap_pct);
  end

  initial begin
    wait (stall_now);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // monitor: compare each popped result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (verdicts_due.size() == 0) begin
        note_error($sformatf("result with nothing expected: verdict %0d reason %0d rule %0d",
                             verdict, reason, matched_rule));
      end else begin
        want = verdicts_due.pop_front();
        if (verdict !== want.verdict)
          note_error($sformatf("verdict got %0d expected %0d", verdict, want.verdict));
        if (reason !== want.reason)
          note_error($sformatf("reason got %0d expected %0d", reason, want.reason));
        if (matched_rule !== want.matched_rule)
          note_error($sformatf("matched_rule got %0d expected %0d",
                               matched_rule, want.matched_rule));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int         p;
    int         n;
    int         roll;
    logic [7:0] data;
    word_t      w;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: filter off, so packets pass untouched
    queue_word(make_packet(DIR_IN, PROTO_TCP, 32'd0, 32'hFFFF_FFFF, 16'd0, 16'hFFFF,
                           XMAS_FLAGS));
    queue_word(rand_packet());

    // fill the whole table before any count covers it
    queue_word(make_rule(4'd0, DIR_IN, PROTO_TCP, 32'h0A00_0001, 32'd0, 16'd0, 16'd80,
                         ACK_CLEAR_OK, VERDICT_ACCEPT));
    queue_word(make_rule(4'd1, DIR_OUT, PROTO_UDP, 32'd0, 32'hC0A8_0001, 16'd2000, 16'd53,
                         ACK_ANY, VERDICT_DROP));
    queue_word(make_rule(4'd2, DIR_BOTH, ANY_PROTOCOL_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         16'hFFFF, 16'd0, ACK_SET_OK, VERDICT_ACCEPT));
    queue_word(make_rule(4'd3, DIR_NONE, ANY_PROTOCOL_RESET, 32'd0, 32'd0, 16'd0, 16'd0,
                         ACK_ANY, VERDICT_DROP));
    queue_word(make_rule(4'd4, DIR_BOTH, PROTO_ICMP, 32'd0, 32'd0, 16'd0, 16'd0,
                         ACK_ANY, VERDICT_DROP));
    queue_word(make_rule(4'd5, DIR_BOTH, PROTO_TCP, 32'd0, 32'd0, 16'd1024, 16'd1024,
                         ACK_ANY, VERDICT_DROP));
    for (n = 6; n < TABLE_DEPTH - 1; n++) begin
      w = rand_rule();
      w.idx = 4'(n);
      queue_word(w);
    end
    // catch-all accept in the last entry
    queue_word(make_rule(4'd15, DIR_BOTH, ANY_PROTOCOL_RESET, 32'd0, 32'd0, 16'd0, 16'd0,
                         ACK_ANY, VERDICT_ACCEPT));
    wait_idle();

    set_reg(CFG_FILTER_ACTIVE, 8'd1);
    set_reg(CFG_RULE_COUNT, 8'd16);
    set_reg(CFG_ANY_PROTOCOL, ANY_PROTOCOL_RESET);

    // christmas-tree packets, with and without ack
    queue_word(make_packet(DIR_IN, PROTO_TCP, 32'($urandom), 32'($urandom), 16'd80, 16'd80,
                           XMAS_FLAGS));
    queue_word(make_packet(DIR_OUT, PROTO_TCP, 32'd0, 32'd0, 16'd0, 16'd0,
                           XMAS_FLAGS | FLAG_ACK));
    // same flags on udp are not special; high port class match
    queue_word(make_packet(DIR_OUT, PROTO_UDP, 32'd0, 32'hC0A8_0001, 16'd5000, 16'd53,
                           XMAS_FLAGS));
    // ack clear allowed only
    queue_word(make_packet(DIR_IN, PROTO_TCP, 32'h0A00_0001, 32'hFFFF_FFFF, 16'd0, 16'd80,
                           4'd0));
    queue_word(make_packet(DIR_IN, PROTO_TCP, 32'h0A00_0001, 32'hFFFF_FFFF, 16'd0, 16'd80,
                           FLAG_ACK));
    // direction 0 matches nothing, direction 3 matches any nonzero mask
    queue_word(make_packet(DIR_NONE, PROTO_UDP, 32'd0, 32'd0, 16'd0, 16'd0, 4'd0));
    queue_word(make_packet(DIR_BOTH, PROTO_ICMP, 32'($urandom), 32'($urandom),
                           16'hFFFF, 16'hFFFF, 4'hF));
    // other protocols see port 0 whatever the header holds
    queue_word(make_packet(DIR_IN, PROTO_GRE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           16'hFFFF, 16'hFFFF, 4'd0));
    queue_word(make_packet(DIR_OUT, PROTO_TCP, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           16'd1024, 16'hFFFF, FLAG_ACK));
    // port boundary just below the high class
    queue_word(make_packet(DIR_BOTH, PROTO_TCP, 32'd0, 32'd0, 16'd1023, 16'd1024, 4'd0));

    // random phases, each under its own register settings
    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      send_gap_pct = (p == 5) ? 0 : 34;
      take_gap_pct = (p == 5) ? 0 : 34;
      data = 8'(($urandom_range(0, 127) << 1) | active_plan[p]);
      set_reg(CFG_FILTER_ACTIVE, data);
      data = (any_plan[p] == RANDOM_SETTING) ? 8'($urandom_range(0, 255)) : 8'(any_plan[p]);
      set_reg(CFG_ANY_PROTOCOL, data);
      data = 8'(($urandom_range(0, 7) << 5) | count_plan[p]);
      set_reg(CFG_RULE_COUNT, data);
      if (p == 6) set_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
      if (p == 2) stall_now = 1'b1;
      for (n = 0; n < PHASE_WORDS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 12) queue_word(rand_rule());
        else if (roll < 80) queue_word(packet_from_table());
        else queue_word(rand_packet());
      end
    end

    wait_idle();
    if (verdicts_due.size() != 0)
      note_error($sformatf("%0d results never arrived", verdicts_due.size()));
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
sv/fmprf_pkg.sv
sv/fmprf_ram.sv
sv/fmprf_fifo.sv
sv/fmprf_front.sv
sv/fmprf_back.sv
sv/first_match_packet_rule_filter.sv
sv/fmprf_checker.sv
tb/first_match_packet_rule_filter_tb.sv
